/* sv/lztd_pkg.sv */
// lztd_pkg: shared types, widths and defaults for the LZ77 triple decoder.
// Used by the channel interfaces and every module of the decoder.
// No dependencies.
package lztd_pkg;

  // defaults for the top-level parameters
  localparam int unsigned HISTORY_DEPTH_DEF = 4096;
  localparam int unsigned MAX_COPY_DEF      = 63;

  // fixed field widths of the channels
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned BYTE_W   = 8;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // one classified triple as it sits in the queue
  typedef struct packed {
    logic [OFFSET_W-1:0] back_offset;
    logic [LEN_W-1:0]    copy_len;     // already limited to MAX_COPY
    logic [BYTE_W-1:0]   literal_byte;
    logic                has_literal;
    logic                copy_req;     // nonzero offset and nonzero length
  } cmd_t;

  // a queue beat: valid plus command
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_beat_t;

  // back-end sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_TAIL
  } back_state_t;

endpackage

/* sv/lztd_if.sv */
// lztd_if: valid/ready channel interfaces for triples in and bytes out.
// Depends on lztd_pkg for field widths.
interface lztd_in_if;
  logic                          valid;
  logic                          ready;
  logic [lztd_pkg::OFFSET_W-1:0] back_offset;
  logic [lztd_pkg::LEN_W-1:0]    copy_length;
  logic [lztd_pkg::BYTE_W-1:0]   literal_byte;
  logic                          has_literal;

  modport source (output valid, back_offset, copy_length, literal_byte, has_literal,
                  input ready);
  modport sink   (input valid, back_offset, copy_length, literal_byte, has_literal,
                  output ready);
endinterface

interface lztd_out_if;
  logic                        valid;
  logic                        ready;
  logic [lztd_pkg::BYTE_W-1:0] out_byte;
  logic                        byte_valid;
  logic                        is_last;
  logic                        offset_error;

  modport source (output valid, out_byte, byte_valid, is_last, offset_error,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, is_last, offset_error,
                  output ready);
endinterface

/* sv/lztd_front.sv */
// lztd_front: accepts triples, limits the copy length and classifies them.
// Depends on lztd_pkg and lztd_in_if.
module lztd_front #(
  parameter int unsigned MAX_COPY = lztd_pkg::MAX_COPY_DEF
) (
  lztd_in_if.sink              in_chan,
  input  logic                 q_ready,
  output lztd_pkg::cmd_beat_t  q_push
);

  localparam int unsigned LW = lztd_pkg::LEN_W;

  logic [LW-1:0] len_lim;

  // clamp the length to the longest supported copy
  always_comb begin
    if (in_chan.copy_length > LW'(MAX_COPY)) begin
      len_lim = LW'(MAX_COPY);
    end else begin
      len_lim = in_chan.copy_length;
    end
  end

  // classify and forward to the queue
  always_comb begin
    q_push.valid            = in_chan.valid;
    q_push.cmd.back_offset  = in_chan.back_offset;
    q_push.cmd.copy_len     = len_lim;
    q_push.cmd.literal_byte = in_chan.literal_byte;
    q_push.cmd.has_literal  = in_chan.has_literal;
    q_push.cmd.copy_req     = (in_chan.back_offset != '0) && (len_lim != '0);
  end

  assign in_chan.ready = q_ready;

endmodule

/* sv/lztd_fifo.sv */
// lztd_fifo: short command queue between front and back of the decoder.
// Depends on lztd_pkg.
module lztd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  lztd_pkg::cmd_beat_t push,
  output logic                push_ready,
  output lztd_pkg::cmd_beat_t head,
  input  logic                pop
);

  localparam int unsigned DEPTH = lztd_pkg::QUEUE_DEPTH;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lztd_pkg::cmd_t entry_r [DEPTH];
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign do_push    = push.valid && push_ready;
  assign head.valid = (count_r != '0);
  assign head.cmd   = entry_r[rd_idx_r];
  assign do_pop     = pop && head.valid;

  // pointer and count update
  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_idx_nxt = (wr_idx_r == IDX_W'(DEPTH - 1)) ? '0 : wr_idx_r + 1'b1;
    end
    if (do_pop) begin
      rd_idx_nxt = (rd_idx_r == IDX_W'(DEPTH - 1)) ? '0 : rd_idx_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      count_r  <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_idx_r] <= push.cmd;
    end
  end

endmodule

/* sv/lztd_back.sv */
// lztd_back: history window, copy sequencer and output register.
// Depends on lztd_pkg, lztd_out_if; fed by lztd_fifo.
module lztd_back #(
  parameter int unsigned HISTORY_DEPTH = lztd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lztd_pkg::cmd_beat_t head,
  output logic                pop,
  lztd_out_if.source          out_chan
);

  localparam int unsigned PW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned OW = lztd_pkg::OFFSET_W;
  localparam int unsigned WW = (CW > OW) ? CW : OW;
  localparam int unsigned LW = lztd_pkg::LEN_W;
  localparam int unsigned BW = lztd_pkg::BYTE_W;

  lztd_pkg::back_state_t state_r, state_nxt;

  // history window
  logic [BW-1:0] hist_mem [HISTORY_DEPTH];
  logic [BW-1:0] rdata_r;
  logic          byp_r;
  logic [BW-1:0] byp_data_r;

  lztd_pkg::cmd_t cmd_r;
  logic           err_r;
  logic [LW-1:0]  cnt_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [PW-1:0]  wp_r, wp_nxt;
  logic [CW-1:0]  bw_r, bw_nxt;
  logic           fetch_vld_r, fetch_vld_nxt;

  logic [BW-1:0]  out_byte_r;
  logic           byte_valid_r, is_last_r, offset_error_r;
  logic           out_valid_r, out_valid_nxt;

  logic [WW-1:0]  off_x, offm_x;
  logic [PW-1:0]  offm, rd0;
  logic [PW:0]    rd_wrap;
  logic           start_err;
  logic           out_free;
  logic [BW-1:0]  fetch_byte;
  logic           issue, emit_copy, emit_tail;
  logic           wr_en;
  logic [BW-1:0]  wr_data;

  // offset check and first read address
  always_comb begin
    off_x     = WW'(head.cmd.back_offset);
    start_err = head.cmd.copy_req && (off_x > WW'(bw_r));
    // an offset of the full window points at the slot about to be overwritten
    offm_x    = (off_x == WW'(HISTORY_DEPTH)) ? '0 : off_x;
    offm      = offm_x[PW-1:0];
    rd_wrap   = {1'b0, wp_r} + (PW+1)'(HISTORY_DEPTH) - {1'b0, offm};
    if (wp_r >= offm) begin
      rd0 = wp_r - offm;
    end else begin
      rd0 = rd_wrap[PW-1:0];
    end
  end

  assign out_free   = !out_valid_r || out_chan.ready;
  assign fetch_byte = byp_r ? byp_data_r : rdata_r;

  // sequencer outputs
  always_comb begin
    pop       = 1'b0;
    issue     = 1'b0;
    emit_copy = 1'b0;
    emit_tail = 1'b0;
    unique case (state_r)
      lztd_pkg::ST_IDLE: begin
        pop = head.valid;
      end
      lztd_pkg::ST_COPY: begin
        emit_copy = fetch_vld_r && out_free;
        issue     = (cnt_r != '0) && (!fetch_vld_r || emit_copy);
      end
      lztd_pkg::ST_TAIL: begin
        emit_tail = out_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lztd_pkg::ST_IDLE: begin
        if (head.valid) begin
          state_nxt = (head.cmd.copy_req && !start_err) ? lztd_pkg::ST_COPY
                                                        : lztd_pkg::ST_TAIL;
        end
      end
      lztd_pkg::ST_COPY: begin
        if (emit_copy && (cnt_r == '0)) begin
          state_nxt = cmd_r.has_literal ? lztd_pkg::ST_TAIL : lztd_pkg::ST_IDLE;
        end
      end
      lztd_pkg::ST_TAIL: begin
        if (out_free) begin
          state_nxt = lztd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lztd_pkg::ST_IDLE;
      end
    endcase
  end

  // window write: copied byte or literal
  assign wr_en   = emit_copy || (emit_tail && cmd_r.has_literal);
  assign wr_data = emit_copy ? fetch_byte : cmd_r.literal_byte;

  // control state update
  always_comb begin
    wp_nxt        = wp_r;
    bw_nxt        = bw_r;
    fetch_vld_nxt = fetch_vld_r;
    out_valid_nxt = out_valid_r;
    if (wr_en) begin
      wp_nxt = (wp_r == PW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (bw_r != CW'(HISTORY_DEPTH)) begin
        bw_nxt = bw_r + 1'b1;
      end
    end
    if (issue) begin
      fetch_vld_nxt = 1'b1;
    end else if (emit_copy) begin
      fetch_vld_nxt = 1'b0;
    end
    if (emit_copy || emit_tail) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lztd_pkg::ST_IDLE;
      wp_r        <= '0;
      bw_r        <= '0;
      fetch_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      bw_r        <= bw_nxt;
      fetch_vld_r <= fetch_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // per-triple working registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r    <= head.cmd;
      err_r    <= start_err;
      cnt_r    <= head.cmd.copy_len;
      rd_ptr_r <= rd0;
    end else if (issue) begin
      cnt_r    <= cnt_r - 1'b1;
      rd_ptr_r <= (rd_ptr_r == PW'(HISTORY_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  // window memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[wp_r] <= wr_data;
    end
    if (issue) begin
      rdata_r <= hist_mem[rd_ptr_r];
    end
  end

  // offset of one reads the byte written in the same cycle
  always_ff @(posedge clk) begin
    if (issue) begin
      byp_r      <= wr_en && (rd_ptr_r == wp_r);
      byp_data_r <= wr_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit_copy) begin
      out_byte_r     <= fetch_byte;
      byte_valid_r   <= 1'b1;
      is_last_r      <= (cnt_r == '0) && !cmd_r.has_literal;
      offset_error_r <= err_r;
    end else if (emit_tail) begin
      out_byte_r     <= cmd_r.has_literal ? cmd_r.literal_byte : '0;
      byte_valid_r   <= cmd_r.has_literal;
      is_last_r      <= 1'b1;
      offset_error_r <= err_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.out_byte     = out_byte_r;
  assign out_chan.byte_valid   = byte_valid_r;
  assign out_chan.is_last      = is_last_r;
  assign out_chan.offset_error = offset_error_r;

endmodule

/* sv/lz77_triple_decoder.sv */
// LZ77 triple decoder. Each accepted triple yields its copied bytes, then its
// literal, one byte per beat, the last beat marked is_last; a triple that emits
// nothing yields one empty beat, and an offset beyond the bytes written so far
// skips the copy and flags offset_error on every beat of that triple. The copy
// engine reads the history window through a single registered read port, one
// byte per cycle while the output does not stall. A triple passes the back end
// states in order: ST_IDLE takes it from the queue, ST_COPY copies its bytes
// (passed over when there is no copy or it is skipped) and ST_TAIL sends its
// literal or empty beat when one follows. A two-entry queue lets the front take
// further triples meanwhile. The window needs no clearing after reset. Depends
// on lztd_pkg, lztd_if, lztd_front, lztd_fifo and lztd_back.
module lz77_triple_decoder #(
  parameter int unsigned HISTORY_DEPTH = lztd_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned MAX_COPY      = lztd_pkg::MAX_COPY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lztd_in_if.sink     in_chan,
  lztd_out_if.source  out_chan
);

  lztd_pkg::cmd_beat_t q_push;
  lztd_pkg::cmd_beat_t q_head;
  logic                q_ready;
  logic                q_pop;

  // accept and classify
  lztd_front #(
    .MAX_COPY (MAX_COPY)
  ) u_front (
    .in_chan (in_chan),
    .q_ready (q_ready),
    .q_push  (q_push)
  );

  // decoupling queue
  lztd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_ready),
    .head       (q_head),
    .pop        (q_pop)
  );

  // copy engine and output
  lztd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .pop      (q_pop),
    .out_chan (out_chan)
  );

endmodule

/* sv/lztd_checker.sv */
// lztd_checker: port-level assertions on the decoder output, bound to the top.
// Depends on lz77_triple_decoder and lztd_pkg.
module lztd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lztd_pkg::BYTE_W-1:0] out_byte,
  input logic                        byte_valid,
  input logic                        is_last,
  input logic                        offset_error
);

  // a stalled beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_valid)
      && $stable(is_last) && $stable(offset_error))
    else $error("output beat changed while stalled");

  // an empty beat closes its triple and carries a zero byte
  a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> is_last && (out_byte == '0))
    else $error("empty beat not last or nonzero");

  // a skipped copy leaves only the literal or the empty beat
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && offset_error |-> is_last)
    else $error("offset error on a copied byte");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind lz77_triple_decoder lztd_checker u_lztd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_byte     (out_chan.out_byte),
  .byte_valid   (out_chan.byte_valid),
  .is_last      (out_chan.is_last),
  .offset_error (out_chan.offset_error)
);
